>>> rtl/core/vcsl_pkg.sv
package vcsl_pkg;

  localparam int VEL_WIDTH_DEF      = 16;
  localparam int TICK_FRAC_BITS_DEF = 16;
  localparam int RATE_WIDTH         = 16;
  localparam int TICK_WIDTH         = 16;
  localparam int CFG_INDEX_WIDTH    = 2;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_TRANS_ACCEL = 2'd0,
    REG_TRANS_DECEL = 2'd1,
    REG_YAW_ACCEL   = 2'd2,
    REG_YAW_DECEL   = 2'd3
  } cfg_reg_t;

endpackage

>>> rtl/core/vcsl_step.sv
module vcsl_step #(
  parameter int VEL_WIDTH      = vcsl_pkg::VEL_WIDTH_DEF,
  parameter int TICK_FRAC_BITS = vcsl_pkg::TICK_FRAC_BITS_DEF
) (
  input  logic [vcsl_pkg::RATE_WIDTH-1:0] rate,
  input  logic [vcsl_pkg::TICK_WIDTH-1:0] tick,
  output logic [VEL_WIDTH:0]              step
);

  localparam int PROD_W = vcsl_pkg::RATE_WIDTH + vcsl_pkg::TICK_WIDTH + VEL_WIDTH + 1;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] scaled;
  logic              sat;

  // A step of 2^VEL_WIDTH already spans the whole velocity range
  assign prod   = PROD_W'(rate) * PROD_W'(tick);
  assign scaled = prod >> TICK_FRAC_BITS;
  assign sat    = (scaled >> (VEL_WIDTH + 1)) != '0;
  assign step   = sat ? {1'b1, {VEL_WIDTH{1'b0}}} : scaled[VEL_WIDTH:0];

endmodule

>>> rtl/core/vcsl_lane.sv
module vcsl_lane #(
  parameter int VEL_WIDTH = vcsl_pkg::VEL_WIDTH_DEF
) (
  input  logic signed [VEL_WIDTH-1:0] cur,
  input  logic signed [VEL_WIDTH-1:0] tgt,
  input  logic        [VEL_WIDTH:0]   up,
  input  logic        [VEL_WIDTH:0]   down,
  output logic signed [VEL_WIDTH-1:0] nxt
);

  localparam int XW = VEL_WIDTH + 2;

  logic signed [XW-1:0] cur_x;
  logic signed [XW-1:0] tgt_x;
  logic signed [XW-1:0] goal;
  logic signed [XW-1:0] abs_cur;
  logic signed [XW-1:0] abs_tgt;
  logic signed [XW-1:0] lim;
  logic signed [XW-1:0] moved;
  logic signed [XW-1:0] res;
  logic                 flip;

  always_comb begin
    cur_x   = XW'(cur);
    tgt_x   = XW'(tgt);
    abs_cur = cur[VEL_WIDTH-1] ? -cur_x : cur_x;
    abs_tgt = tgt[VEL_WIDTH-1] ? -tgt_x : tgt_x;
    // opposite signs: brake toward zero first
    flip    = (cur != '0) && (tgt != '0) && (cur[VEL_WIDTH-1] != tgt[VEL_WIDTH-1]);
    goal    = flip ? '0 : tgt_x;
    if (flip || (abs_tgt < abs_cur)) begin
      lim = $signed({1'b0, down});
    end else begin
      lim = $signed({1'b0, up});
    end
    if (goal > cur_x) begin
      moved = cur_x + lim;
      res   = (moved < goal) ? moved : goal;
    end else begin
      moved = cur_x - lim;
      res   = (moved > goal) ? moved : goal;
    end
    nxt = res[VEL_WIDTH-1:0];
  end

endmodule

>>> rtl/core/velocity_command_slew_limiter.sv
// A transaction is registered in stage 1 (targets and steps), then in the held state,
// which is the output register. Throughput: one transaction per cycle while m_tready
// does not stall the output; the multiply stage feeds the per-axis update stage.
// Reset (rst, synchronous): rate registers cleared to 0 (invalid until written),
// held velocities cleared to 0, pipeline emptied.
module velocity_command_slew_limiter #(
  parameter int VEL_WIDTH      = vcsl_pkg::VEL_WIDTH_DEF,
  parameter int TICK_FRAC_BITS = vcsl_pkg::TICK_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [vcsl_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [vcsl_pkg::RATE_WIDTH-1:0]       cfg_wdata,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // target_vx, target_vy, target_yaw, tick_length
  input  logic [((3*VEL_WIDTH+vcsl_pkg::TICK_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // out_vx, out_vy, out_yaw
  output logic [((3*VEL_WIDTH+7)/8)*8-1:0]      m_tdata,
  // was_reset, set when an invalid config or zero tick cleared the velocities
  output logic                                  m_tuser
);

  localparam int TW    = vcsl_pkg::TICK_WIDTH;
  localparam int RW    = vcsl_pkg::RATE_WIDTH;
  localparam int OUT_W = ((3*VEL_WIDTH+7)/8)*8;

  logic [RW-1:0] trans_accel;
  logic [RW-1:0] trans_decel;
  logic [RW-1:0] yaw_accel;
  logic [RW-1:0] yaw_decel;

  always_ff @(posedge clk) begin
    if (rst) begin
      trans_accel <= '0;
      trans_decel <= '0;
      yaw_accel   <= '0;
      yaw_decel   <= '0;
    end else if (cfg_we) begin
      case (vcsl_pkg::cfg_reg_t'(cfg_index))
        vcsl_pkg::REG_TRANS_ACCEL: trans_accel <= cfg_wdata;
        vcsl_pkg::REG_TRANS_DECEL: trans_decel <= cfg_wdata;
        vcsl_pkg::REG_YAW_ACCEL:   yaw_accel   <= cfg_wdata;
        vcsl_pkg::REG_YAW_DECEL:   yaw_decel   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input field split
  logic signed [VEL_WIDTH-1:0] in_vx;
  logic signed [VEL_WIDTH-1:0] in_vy;
  logic signed [VEL_WIDTH-1:0] in_yaw;
  logic        [TW-1:0]        in_tick;

  assign in_vx   = $signed(s_tdata[VEL_WIDTH-1:0]);
  assign in_vy   = $signed(s_tdata[2*VEL_WIDTH-1:VEL_WIDTH]);
  assign in_yaw  = $signed(s_tdata[3*VEL_WIDTH-1:2*VEL_WIDTH]);
  assign in_tick = s_tdata[3*VEL_WIDTH+TW-1:3*VEL_WIDTH];

  logic [VEL_WIDTH:0] ta_step;
  logic [VEL_WIDTH:0] td_step;
  logic [VEL_WIDTH:0] ya_step;
  logic [VEL_WIDTH:0] yd_step;

  vcsl_step #(.VEL_WIDTH(VEL_WIDTH), .TICK_FRAC_BITS(TICK_FRAC_BITS)) u_step_ta (
    .rate(trans_accel), .tick(in_tick), .step(ta_step)
  );
  vcsl_step #(.VEL_WIDTH(VEL_WIDTH), .TICK_FRAC_BITS(TICK_FRAC_BITS)) u_step_td (
    .rate(trans_decel), .tick(in_tick), .step(td_step)
  );
  vcsl_step #(.VEL_WIDTH(VEL_WIDTH), .TICK_FRAC_BITS(TICK_FRAC_BITS)) u_step_ya (
    .rate(yaw_accel), .tick(in_tick), .step(ya_step)
  );
  vcsl_step #(.VEL_WIDTH(VEL_WIDTH), .TICK_FRAC_BITS(TICK_FRAC_BITS)) u_step_yd (
    .rate(yaw_decel), .tick(in_tick), .step(yd_step)
  );

  // stage 1: targets and steps
  logic                        s1_valid;
  logic                        s1_bad;
  logic signed [VEL_WIDTH-1:0] s1_vx;
  logic signed [VEL_WIDTH-1:0] s1_vy;
  logic signed [VEL_WIDTH-1:0] s1_yaw;
  logic        [VEL_WIDTH:0]   s1_ta;
  logic        [VEL_WIDTH:0]   s1_td;
  logic        [VEL_WIDTH:0]   s1_ya;
  logic        [VEL_WIDTH:0]   s1_yd;

  // held state doubles as the output register
  logic signed [VEL_WIDTH-1:0] held_vx;
  logic signed [VEL_WIDTH-1:0] held_vy;
  logic signed [VEL_WIDTH-1:0] held_yaw;
  logic                        out_valid;
  logic                        out_bad;

  logic advance;
  logic s_accept;

  assign advance  = s1_valid && (!out_valid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_vx  <= in_vx;
      s1_vy  <= in_vy;
      s1_yaw <= in_yaw;
      s1_ta  <= ta_step;
      s1_td  <= td_step;
      s1_ya  <= ya_step;
      s1_yd  <= yd_step;
      s1_bad <= (trans_accel == '0) || (trans_decel == '0) || (yaw_accel == '0) ||
                (yaw_decel == '0) || (in_tick == '0);
    end
  end

  logic signed [VEL_WIDTH-1:0] held_vx_next;
  logic signed [VEL_WIDTH-1:0] held_vy_next;
  logic signed [VEL_WIDTH-1:0] held_yaw_next;

  vcsl_lane #(.VEL_WIDTH(VEL_WIDTH)) u_lane_vx (
    .cur(held_vx), .tgt(s1_vx), .up(s1_ta), .down(s1_td), .nxt(held_vx_next)
  );
  vcsl_lane #(.VEL_WIDTH(VEL_WIDTH)) u_lane_vy (
    .cur(held_vy), .tgt(s1_vy), .up(s1_ta), .down(s1_td), .nxt(held_vy_next)
  );
  vcsl_lane #(.VEL_WIDTH(VEL_WIDTH)) u_lane_yaw (
    .cur(held_yaw), .tgt(s1_yaw), .up(s1_ya), .down(s1_yd), .nxt(held_yaw_next)
  );

  // merge: invalid config or zero tick clears all three axes
  always_ff @(posedge clk) begin
    if (rst) begin
      held_vx   <= '0;
      held_vy   <= '0;
      held_yaw  <= '0;
      out_valid <= 1'b0;
      out_bad   <= 1'b0;
    end else begin
      if (advance) begin
        held_vx   <= s1_bad ? '0 : held_vx_next;
        held_vy   <= s1_bad ? '0 : held_vy_next;
        held_yaw  <= s1_bad ? '0 : held_yaw_next;
        out_bad   <= s1_bad;
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_bad;
  assign m_tdata  = OUT_W'({held_yaw, held_vy, held_vx});

  a_reset_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_bad) |-> (held_vx == '0 && held_vy == '0 && held_yaw == '0))
    else $error("cleared result carries nonzero velocity");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !m_tready) |=>
      ($stable(held_vx) && $stable(held_vy) && $stable(held_yaw) && $stable(out_bad)))
    else $error("held state changed while result stalled");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> s_tready)
    else $error("empty stage refused a transaction");

  a_advance_valid: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("advanced item did not reach output");

endmodule
